>>> rtl/bssp_pkg.sv
// ----------------------------------------------------------------------------
// bssp_pkg
// Shared codes and types for the beacon SSID parser with BSSID table.
// ----------------------------------------------------------------------------
`default_nettype none

package bssp_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES    = 16;
  localparam int unsigned DEF_SSID_MAX_BYTES   = 32;
  localparam int unsigned DEF_MAX_BUFFER_BYTES = 2048;

  // input ops
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_SSID    = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // result status
  localparam logic [2:0] ST_REJECT = 3'd0;
  localparam logic [2:0] ST_NEW    = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_NOENT  = 3'd4;

  // commands from front to back
  localparam logic [1:0] CMD_FINISH = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic        ok;
    logic [47:0] bssid;
    logic [3:0]  channel;
    logic [5:0]  ssid_size;
    logic [3:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [3:0]  idx;
    logic [4:0]  count;
    logic [47:0] bssid;
    logic [3:0]  channel;
    logic [5:0]  ssid_size;
    logic [7:0]  ssid_byte;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/bssp_front.sv
// ----------------------------------------------------------------------------
// bssp_front
// Byte-level frame parser: type check, BSSID capture, element walk, SSID
// capture buffer. Pushes finish/clear/read commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bssp_front
  import bssp_pkg::*;
#(
  parameter int unsigned SSID_MAX_BYTES   = DEF_SSID_MAX_BYTES,
  parameter int unsigned MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [3:0]  entry_index_i,
  output logic             push_o,
  output cmd_t             push_cmd_o,
  input  wire logic        q_ready_i,
  input  wire logic        frame_done_i,
  input  wire logic        cap_rd_en_i,
  input  wire logic [((SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1)-1:0] cap_rd_addr_i,
  output logic [7:0]       cap_rd_data_o
);

  localparam int unsigned SAddrW   = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;
  localparam int unsigned PosLimit = (MAX_BUFFER_BYTES < 4095) ? MAX_BUFFER_BYTES : 4095;

  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [11:0] pos_q, pos_d;
  logic        type_ok_q, type_ok_d;
  logic [47:0] bssid_q, bssid_d;
  logic [1:0]  phase_q, phase_d;
  logic        is_ssid_q, is_ssid_d;
  logic [7:0]  remain_q, remain_d;
  logic        stopped_q, stopped_d;
  logic [5:0]  found_q, found_d;
  logic        busy_q;
  logic        cap_we;
  logic        accept, take, finish;

  logic [7:0]  cap_mem [SSID_MAX_BYTES];

  assign in_ready_o = !busy_q && q_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = (op_i == OP_BYTE) && (pos_q < 12'(PosLimit));
  assign finish     = accept && (op_i == OP_BYTE) && last_byte_i;

  always_comb begin
    pos_d     = pos_q;
    type_ok_d = type_ok_q;
    bssid_d   = bssid_q;
    phase_d   = phase_q;
    is_ssid_d = is_ssid_q;
    remain_d  = remain_q;
    stopped_d = stopped_q;
    found_d   = found_q;
    cap_we    = 1'b0;
    if (take) begin
      pos_d = pos_q + 12'd1;
      if (pos_q == 12'd24) begin
        type_ok_d = ((data_byte_i & 8'hFC) == 8'h80);
      end
      if (pos_q >= 12'd40 && pos_q <= 12'd45) begin
        bssid_d = {bssid_q[39:0], data_byte_i};
      end
      // element walk starts at frame offset 60
      if (pos_q >= 12'd60 && !stopped_q) begin
        unique case (phase_q)
          PH_TAG: begin
            is_ssid_d = (data_byte_i == 8'h00);
            phase_d   = PH_LEN;
          end
          PH_LEN: begin
            remain_d = data_byte_i;
            if (data_byte_i == 8'h00) begin
              if (is_ssid_q) stopped_d = 1'b1;
              phase_d = PH_TAG;
            end else begin
              phase_d = PH_BODY;
            end
          end
          default: begin
            if (is_ssid_q && found_q < 6'(SSID_MAX_BYTES)) begin
              cap_we  = 1'b1;
              found_d = found_q + 6'd1;
            end
            remain_d = remain_q - 8'd1;
            if (remain_q == 8'd1) begin
              if (is_ssid_q) stopped_d = 1'b1;
              phase_d = PH_TAG;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push_o     = 1'b0;
    push_cmd_o = '0;
    if (accept) begin
      case (op_i)
        OP_BYTE: begin
          push_o               = last_byte_i;
          push_cmd_o.op        = CMD_FINISH;
          push_cmd_o.ok        = (pos_d >= 12'd62) && type_ok_d;
          push_cmd_o.bssid     = bssid_d;
          push_cmd_o.channel   = channel_i;
          push_cmd_o.ssid_size = stopped_d ? found_d : 6'd0;
        end
        OP_CLEAR: begin
          push_o        = 1'b1;
          push_cmd_o.op = CMD_CLEAR;
        end
        OP_READ: begin
          push_o         = 1'b1;
          push_cmd_o.op  = CMD_READ;
          push_cmd_o.idx = entry_index_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      type_ok_q <= 1'b0;
      bssid_q   <= '0;
      phase_q   <= PH_TAG;
      is_ssid_q <= 1'b0;
      remain_q  <= '0;
      stopped_q <= 1'b0;
      found_q   <= '0;
      busy_q    <= 1'b0;
    end else begin
      if (finish) begin
        pos_q     <= '0;
        type_ok_q <= 1'b0;
        bssid_q   <= '0;
        phase_q   <= PH_TAG;
        is_ssid_q <= 1'b0;
        remain_q  <= '0;
        stopped_q <= 1'b0;
        found_q   <= '0;
      end else if (accept && op_i == OP_BYTE) begin
        pos_q     <= pos_d;
        type_ok_q <= type_ok_d;
        bssid_q   <= bssid_d;
        phase_q   <= phase_d;
        is_ssid_q <= is_ssid_d;
        remain_q  <= remain_d;
        stopped_q <= stopped_d;
        found_q   <= found_d;
      end
      // hold off input until the back end signals that it is done with the frame
      if (finish) begin
        busy_q <= 1'b1;
      end else if (frame_done_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cap_we) begin
      cap_mem[found_q[SAddrW-1:0]] <= data_byte_i;
    end
    if (cap_rd_en_i) begin
      cap_rd_data_o <= cap_mem[cap_rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bssp_queue.sv
// ----------------------------------------------------------------------------
// bssp_queue
// Small command FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bssp_queue
  import bssp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      not_full_o,
  output logic      pop_valid_o,
  output cmd_t      pop_cmd_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign not_full_o  = (cnt_q != (PtrW + 1)'(QUEUE_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_cmd_o   = mem_q[rptr_q];
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

>>> rtl/bssp_back.sv
// ----------------------------------------------------------------------------
// bssp_back
// BSSID table: sequential lookup, entry store with SSID copy, clear and
// entry read-back. Drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bssp_back
  import bssp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES  = DEF_TABLE_ENTRIES,
  parameter int unsigned SSID_MAX_BYTES = DEF_SSID_MAX_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             frame_done_o,
  output logic             cap_rd_en_o,
  output logic [((SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1)-1:0] cap_rd_addr_o,
  input  wire logic [7:0]  cap_rd_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output res_t             out_o
);

  localparam int unsigned SAddrW   = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;
  localparam int unsigned TIdxW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW     = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned MemDepth = TABLE_ENTRIES << SAddrW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_COPY    = 3'd2;
  localparam logic [2:0] S_COMMIT  = 3'd3;
  localparam logic [2:0] S_RD_HDR  = 3'd4;
  localparam logic [2:0] S_RD_ADDR = 3'd5;
  localparam logic [2:0] S_RD_EMIT = 3'd6;

  logic [2:0]       st_q, st_d;
  cmd_t             cur_q, cur_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [5:0]       ck_q, ck_d;
  logic             wv_q;
  logic [SAddrW-1:0] wk_q;
  logic             out_valid_q;
  res_t             out_q;
  logic             out_free, emit, tbl_we, mem_rd_en;
  res_t             res;
  logic [TIdxW-1:0] tbl_addr, cur_row;
  logic [47:0]      tbl_bssid_rd;
  logic [5:0]       tbl_len_rd;
  logic [3:0]       tbl_ch_rd;
  logic [7:0]       mem_rd_data_q;

  logic [47:0] tbl_bssid [TABLE_ENTRIES];
  logic [5:0]  tbl_len   [TABLE_ENTRIES];
  logic [3:0]  tbl_ch    [TABLE_ENTRIES];
  logic [7:0]  ssid_mem  [MemDepth];

  assign out_free     = !out_valid_q || out_ready_i;
  assign cur_row      = TIdxW'(cur_q.idx);
  assign tbl_addr     = (st_q == S_SEARCH) ? k_q[TIdxW-1:0] : cur_row;
  assign tbl_bssid_rd = tbl_bssid[tbl_addr];
  assign tbl_len_rd   = tbl_len[tbl_addr];
  assign tbl_ch_rd    = tbl_ch[tbl_addr];
  assign cap_rd_addr_o = ck_q[SAddrW-1:0];

  always_comb begin
    st_d         = st_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    ck_d         = ck_q;
    emit         = 1'b0;
    res          = '0;
    res.last     = 1'b1;
    res.count    = 5'(cnt_q);
    frame_done_o = 1'b0;
    cmd_pop_o    = 1'b0;
    cap_rd_en_o  = 1'b0;
    mem_rd_en    = 1'b0;
    tbl_we       = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          case (cmd_i.op)
            CMD_CLEAR: begin
              emit      = 1'b1;
              res.kind  = KIND_CLEAR;
              res.count = 5'd0;
              cnt_d     = '0;
            end
            CMD_READ: begin
              if (8'(cmd_i.idx) >= 8'(cnt_q)) begin
                emit       = 1'b1;
                res.kind   = KIND_HEADER;
                res.status = ST_NOENT;
                res.idx    = cmd_i.idx;
              end else begin
                st_d = S_RD_HDR;
              end
            end
            CMD_FINISH: begin
              if (!cmd_i.ok) begin
                emit         = 1'b1;
                res.kind     = KIND_VERDICT;
                res.status   = ST_REJECT;
                frame_done_o = 1'b1;
              end else begin
                k_d  = '0;
                st_d = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        // one table entry compared per cycle
        if (k_q == cnt_q) begin
          if (cnt_q >= CntW'(TABLE_ENTRIES)) begin
            if (out_free) begin
              emit         = 1'b1;
              res.kind     = KIND_VERDICT;
              res.status   = ST_FULL;
              res.bssid    = cur_q.bssid;
              frame_done_o = 1'b1;
              st_d         = S_IDLE;
            end
          end else begin
            ck_d = '0;
            st_d = S_COPY;
          end
        end else if (tbl_bssid_rd == cur_q.bssid) begin
          if (out_free) begin
            emit          = 1'b1;
            res.kind      = KIND_VERDICT;
            res.status    = ST_DUP;
            res.idx       = 4'(k_q);
            res.bssid     = cur_q.bssid;
            res.channel   = tbl_ch_rd;
            res.ssid_size = tbl_len_rd;
            frame_done_o  = 1'b1;
            st_d          = S_IDLE;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_COPY: begin
        if (ck_q < cur_q.ssid_size) begin
          cap_rd_en_o = 1'b1;
          ck_d        = ck_q + 6'd1;
        end else if (!wv_q) begin
          st_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          tbl_we        = 1'b1;
          cnt_d         = cnt_q + 1'b1;
          emit          = 1'b1;
          res.kind      = KIND_VERDICT;
          res.status    = ST_NEW;
          res.idx       = 4'(cnt_q);
          res.count     = 5'(cnt_q + 1'b1);
          res.bssid     = cur_q.bssid;
          res.channel   = cur_q.channel;
          res.ssid_size = cur_q.ssid_size;
          frame_done_o  = 1'b1;
          st_d          = S_IDLE;
        end
      end
      S_RD_HDR: begin
        if (out_free) begin
          emit          = 1'b1;
          res.kind      = KIND_HEADER;
          res.status    = ST_NEW;
          res.idx       = cur_q.idx;
          res.bssid     = tbl_bssid_rd;
          res.channel   = tbl_ch_rd;
          res.ssid_size = tbl_len_rd;
          res.last      = (tbl_len_rd == 6'd0);
          ck_d          = '0;
          st_d          = (tbl_len_rd == 6'd0) ? S_IDLE : S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        mem_rd_en = 1'b1;
        st_d      = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (out_free) begin
          emit          = 1'b1;
          res.kind      = KIND_SSID;
          res.status    = ST_NEW;
          res.idx       = cur_q.idx;
          res.bssid     = tbl_bssid_rd;
          res.channel   = tbl_ch_rd;
          res.ssid_size = tbl_len_rd;
          res.ssid_byte = mem_rd_data_q;
          res.last      = ((ck_q + 6'd1) == tbl_len_rd);
          ck_d          = ck_q + 6'd1;
          st_d          = ((ck_q + 6'd1) == tbl_len_rd) ? S_IDLE : S_RD_ADDR;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      ck_q        <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      k_q   <= k_d;
      ck_q  <= ck_d;
      wv_q  <= cap_rd_en_o;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    wk_q  <= ck_q[SAddrW-1:0];
    if (emit) out_q <= res;
    if (tbl_we) begin
      tbl_bssid[cnt_q[TIdxW-1:0]] <= cur_q.bssid;
      tbl_len[cnt_q[TIdxW-1:0]]   <= cur_q.ssid_size;
      tbl_ch[cnt_q[TIdxW-1:0]]    <= cur_q.channel;
    end
  end

  // SSID store: written during copy, read during read-back
  always_ff @(posedge clk_i) begin
    if (wv_q) begin
      ssid_mem[{cnt_q[TIdxW-1:0], wk_q}] <= cap_rd_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      mem_rd_data_q <= ssid_mem[{cur_row, ck_q[SAddrW-1:0]}];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_ENTRIES))
    else $error("table count above capacity");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (cnt_q < CntW'(TABLE_ENTRIES)))
    else $error("store into a full table");

  a_copy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (st_q == S_COPY) && $past(cap_rd_en_o))
    else $error("SSID write outside copy");

  a_done_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done_o |-> emit && (res.kind == KIND_VERDICT))
    else $error("frame done without a verdict");

endmodule

`default_nettype wire

>>> rtl/beacon_ssid_parser_with_bssid_table.sv
// ----------------------------------------------------------------------------
// beacon_ssid_parser_with_bssid_table
// Beacon parser front end, command queue and BSSID table back end.
// ----------------------------------------------------------------------------
// Buffer bytes are taken one per cycle while in_ready_o is high. After the
// final byte of a frame the input stalls until the table work for that frame
// ends: the BSSID search walks the stored entries, then for a new entry the
// SSID is copied and the entry committed. A read-back gives its header and
// then its SSID bytes, the SSID store having a registered read. Results sit
// in an output register; a new command is taken only when that register is
// empty or its result is being taken.
`default_nettype none

module beacon_ssid_parser_with_bssid_table
  import bssp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
  parameter int unsigned SSID_MAX_BYTES   = DEF_SSID_MAX_BYTES,
  parameter int unsigned MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [3:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [2:0]       status_o,
  output logic [3:0]       entry_index_res_o,
  output logic [4:0]       entry_count_o,
  output logic [47:0]      bssid_o,
  output logic [3:0]       channel_res_o,
  output logic [5:0]       ssid_size_o,
  output logic [7:0]       ssid_byte_o,
  output logic             last_result_o
);

  localparam int unsigned SAddrW = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;

  logic              push, q_not_full, q_valid, pop, frame_done;
  cmd_t              push_cmd, q_cmd;
  logic              cap_rd_en;
  logic [SAddrW-1:0] cap_rd_addr;
  logic [7:0]        cap_rd_data;
  res_t              res;

  bssp_front #(
    .SSID_MAX_BYTES  (SSID_MAX_BYTES),
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .channel_i    (channel_i),
    .entry_index_i(entry_index_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .q_ready_i    (q_not_full),
    .frame_done_i (frame_done),
    .cap_rd_en_i  (cap_rd_en),
    .cap_rd_addr_i(cap_rd_addr),
    .cap_rd_data_o(cap_rd_data)
  );

  bssp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .not_full_o (q_not_full),
    .pop_valid_o(q_valid),
    .pop_cmd_o  (q_cmd),
    .pop_i      (pop)
  );

  bssp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SSID_MAX_BYTES(SSID_MAX_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (pop),
    .frame_done_o (frame_done),
    .cap_rd_en_o  (cap_rd_en),
    .cap_rd_addr_o(cap_rd_addr),
    .cap_rd_data_i(cap_rd_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign kind_o            = res.kind;
  assign status_o          = res.status;
  assign entry_index_res_o = res.idx;
  assign entry_count_o     = res.count;
  assign bssid_o           = res.bssid;
  assign channel_res_o     = res.channel;
  assign ssid_size_o       = res.ssid_size;
  assign ssid_byte_o       = res.ssid_byte;
  assign last_result_o     = res.last;

endmodule

`default_nettype wire
